[rtl/aed_pkg.sv]
// shared types, constants and register codes of the atkinson dither
package aed_pkg;

  localparam int PIX_W        = 8;
  localparam int ERR_W        = 6;
  localparam int ERR_SHIFT    = 3;
  localparam int NUM_CH       = 4;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CHANNELS_DEF  = 4;

  localparam logic [PIX_W-1:0]        PIX_MAX          = 8'd255;
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET      = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET     = 16'd480;
  localparam logic [PIX_W-1:0]        THRESHOLD_RESET  = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_LEVEL_THRESHOLD = 2'd2
  } cfg_index_e;

  // which of the six neighbour terms lie inside the image
  typedef struct packed {
    logic two_up;
    logic up_left;
    logic up;
    logic up_right;
    logic two_left;
    logic left;
  } aed_gate_t;

endpackage

[rtl/aed_channel.sv]
// one colour channel: clamped error accumulation, threshold and error term
module aed_channel (
  input  logic [aed_pkg::PIX_W-1:0]        pix_i,
  input  logic [aed_pkg::PIX_W-1:0]        thr_i,
  input  aed_pkg::aed_gate_t               gate_i,
  input  logic signed [aed_pkg::ERR_W-1:0] two_up_err_i,
  input  logic signed [aed_pkg::ERR_W-1:0] up_left_err_i,
  input  logic signed [aed_pkg::ERR_W-1:0] up_err_i,
  input  logic signed [aed_pkg::ERR_W-1:0] up_right_err_i,
  input  logic signed [aed_pkg::ERR_W-1:0] two_left_err_i,
  input  logic signed [aed_pkg::ERR_W-1:0] left_err_i,
  output logic                             on_o,
  output logic signed [aed_pkg::ERR_W-1:0] err_o
);
  import aed_pkg::*;

  logic [PIX_W-1:0] v;
  logic [PIX_W-1:0] d;

  function automatic logic [PIX_W-1:0] add_clamp(input logic [PIX_W-1:0] a,
                                                 input logic signed [ERR_W-1:0] e);
    logic signed [PIX_W+1:0] s;
    begin
      s = $signed({2'b00, a}) + (PIX_W+2)'(e);
      if (s < 0) begin
        add_clamp = '0;
      end else if (s > $signed({2'b00, PIX_MAX})) begin
        add_clamp = PIX_MAX;
      end else begin
        add_clamp = PIX_W'(s);
      end
    end
  endfunction

  always_comb begin
    v = pix_i;
    if (gate_i.two_up)   v = add_clamp(v, two_up_err_i);
    if (gate_i.up_left)  v = add_clamp(v, up_left_err_i);
    if (gate_i.up)       v = add_clamp(v, up_err_i);
    if (gate_i.up_right) v = add_clamp(v, up_right_err_i);
    if (gate_i.two_left) v = add_clamp(v, two_left_err_i);
    if (gate_i.left)     v = add_clamp(v, left_err_i);
  end

  assign on_o = (v >= thr_i);
  assign d    = PIX_MAX - v;

  // truncation toward zero of (v - new) / 8
  assign err_o = on_o ? -$signed(ERR_W'(d[PIX_W-1:ERR_SHIFT]))
                      :  $signed(ERR_W'(v[PIX_W-1:ERR_SHIFT]));

endmodule

[rtl/atkinson_error_diffusion_dither.sv]
// top level of the atkinson error diffusion dither with its line buffers
//
// pixels enter in raster order on the s_axis channel, four 8-bit channels
// in tdata, and leave on m_axis as one bit per channel (1 means 255) with
// tlast marking the last pixel of a frame. one item is taken per cycle; the
// result is registered in the cycle after acceptance. throughput
// is one pixel per clock, set by the single read-modify-write of the two
// line buffer memories per pixel; a three-entry window of the previous row
// and prefetched reads keep the memories at one access per port and cycle.
// when the receiver stalls with a result waiting, s_axis_tready falls and
// the item is held; it rises again the cycle the result is taken.
// the configuration channel (width, height, threshold) is always ready; the
// user must write it between frames or while no item is in flight, which
// the block does not enforce. reset clears the row and column counters,
// the left error registers and the output register; the line buffers are
// not cleared, as an entry is only used after it was written this frame.
module atkinson_error_diffusion_dither #(
  parameter int MAX_WIDTH = aed_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = aed_pkg::CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [aed_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [aed_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // red_in, green_in, blue_in, alpha_in
  input  logic [31:0]                      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red_on, green_on, blue_on, alpha_on, zero fill
  output logic [7:0]                       m_axis_tdata,
  // frame_end
  output logic                             m_axis_tlast
);
  import aed_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = ((WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W) + 1;
  localparam int MW = CHANNELS * ERR_W;

  logic [CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [CFG_HEIGHT_W-1:0] cfg_height_q;
  logic [PIX_W-1:0]        cfg_thr_q;

  logic [XW-1:0]           col_q;
  logic [CFG_HEIGHT_W-1:0] row_q;
  logic [MW-1:0]           l1_q, l2_q;
  logic [MW-1:0]           pm1_q, p0_q;
  logic                    row_start_q;
  logic                    m_valid_q;
  logic [NUM_CH-1:0]       m_on_q;
  logic                    m_last_q;

  logic [MW-1:0] prev_mem [MAX_WIDTH];
  logic [MW-1:0] sec_mem  [MAX_WIDTH];
  logic [MW-1:0] pa_raw_q, pb_raw_q, s_raw_q;
  logic          pa_fwd_q, pb_fwd_q, s_fwd_q;
  logic [MW-1:0] p_wr_q, s_wr_q;

  logic                    s_acc;
  logic [WW-1:0]           w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;
  logic [EW-1:0]           x_ext, w_ext;
  logic                    last_col, last_row;
  logic [XW-1:0]           col_d, pa_addr;
  logic [CFG_HEIGHT_W-1:0] row_d;
  aed_gate_t               gate;
  logic [MW-1:0]           p1_cur, p0_cur, s_cur, err_all;
  logic [NUM_CH-1:0]       on_all;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RESET;
      cfg_height_q <= HEIGHT_RESET;
      cfg_thr_q    <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:     cfg_width_q  <= cfg_data_i[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:    cfg_height_q <= cfg_data_i[CFG_HEIGHT_W-1:0];
        CFG_LEVEL_THRESHOLD: cfg_thr_q    <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WW'(1);
    end else if (EW'(cfg_width_q) > EW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_q);
    end
    h_eff = (cfg_height_q == '0) ? CFG_HEIGHT_W'(1) : cfg_height_q;
  end

  assign x_ext    = EW'(col_q);
  assign w_ext    = EW'(w_eff);
  assign last_col = (x_ext + EW'(1)) >= w_ext;
  assign last_row = ({1'b0, row_q} + (CFG_HEIGHT_W+1)'(1)) >= {1'b0, h_eff};
  assign col_d    = last_col ? '0 : col_q + XW'(1);
  assign row_d    = last_row ? '0 : row_q + CFG_HEIGHT_W'(1);
  assign pa_addr  = last_col ? XW'(1) : col_q + XW'(2);

  always_comb begin
    gate.two_up   = (row_q >= CFG_HEIGHT_W'(2)) && (x_ext < w_ext);
    gate.up_left  = (row_q != '0) && (col_q != '0) && (x_ext <= w_ext);
    gate.up       = (row_q != '0) && (x_ext < w_ext);
    gate.up_right = (row_q != '0) && ((x_ext + EW'(1)) < w_ext);
    gate.two_left = (col_q >= XW'(2));
    gate.left     = (col_q != '0);
  end

  // previous row window: p0 comes from the row start read at column zero
  assign p1_cur = pa_fwd_q ? p_wr_q : pa_raw_q;
  assign p0_cur = row_start_q ? (pb_fwd_q ? p_wr_q : pb_raw_q) : p0_q;
  assign s_cur  = s_fwd_q ? s_wr_q : s_raw_q;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    if (c < CHANNELS) begin : g_on
      logic signed [ERR_W-1:0] err_c;
      aed_channel u_channel (
        .pix_i          (s_axis_tdata[c*PIX_W +: PIX_W]),
        .thr_i          (cfg_thr_q),
        .gate_i         (gate),
        .two_up_err_i   ($signed(s_cur[c*ERR_W +: ERR_W])),
        .up_left_err_i  ($signed(pm1_q[c*ERR_W +: ERR_W])),
        .up_err_i       ($signed(p0_cur[c*ERR_W +: ERR_W])),
        .up_right_err_i ($signed(p1_cur[c*ERR_W +: ERR_W])),
        .two_left_err_i ($signed(l2_q[c*ERR_W +: ERR_W])),
        .left_err_i     ($signed(l1_q[c*ERR_W +: ERR_W])),
        .on_o           (on_all[c]),
        .err_o          (err_c)
      );
      assign err_all[c*ERR_W +: ERR_W] = err_c;
    end else begin : g_off
      assign on_all[c] = 1'b0;
    end
  end

  // line buffers with registered reads and write forwarding
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      prev_mem[col_q] <= err_all;
      sec_mem[col_q]  <= p0_cur;
      pa_raw_q        <= prev_mem[pa_addr];
      pb_raw_q        <= prev_mem[XW'(0)];
      s_raw_q         <= sec_mem[col_d];
      pa_fwd_q        <= (pa_addr == col_q);
      pb_fwd_q        <= (col_q == '0);
      s_fwd_q         <= (col_d == col_q);
      p_wr_q          <= err_all;
      s_wr_q          <= p0_cur;
      pm1_q           <= p0_cur;
      p0_q            <= p1_cur;
    end
  end

  // counters, left errors and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      l1_q        <= '0;
      l2_q        <= '0;
      row_start_q <= 1'b1;
      m_valid_q   <= 1'b0;
      m_on_q      <= '0;
      m_last_q    <= 1'b0;
    end else begin
      if (s_acc) begin
        col_q       <= col_d;
        row_start_q <= last_col;
        if (last_col) row_q <= row_d;
        l2_q        <= l1_q;
        l1_q        <= err_all;
        m_valid_q   <= 1'b1;
        m_on_q      <= on_all;
        m_last_q    <= last_col && last_row;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_on_q};
  assign m_axis_tlast  = m_last_q;

  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_start_q == (col_q == '0))
    else $error("row start flag out of step with column counter");

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && last_col |=> col_q == '0)
    else $error("column counter did not wrap at row end");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !last_col |=> col_q == $past(col_q) + XW'(1))
    else $error("column counter did not advance");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready |-> !s_acc)
    else $error("item accepted while result stalled");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> m_valid_q)
    else $error("accepted item produced no result");

endmodule
